### rtl/twcs_pkg.sv
// ----------------------------------------------------------------------------
// twcs_pkg
// Types, codes and constants shared by the text window cell store.
// ----------------------------------------------------------------------------
package twcs_pkg;

	localparam int APB_ADDR_W   = 3;
	localparam int APB_DATA_W   = 32;
	localparam int REG_ADDR_LSB = 2;

	localparam int WIN_WIDTH_W  = 8;
	localparam int WIN_HEIGHT_W = 7;

	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 40;

	localparam int COLOR_W = 5;
	localparam int PAIR_W  = 8;
	localparam int CELL_W  = 18;

	localparam logic [WIN_WIDTH_W-1:0]  WIN_WIDTH_RST  = 8'd80;
	localparam logic [WIN_HEIGHT_W-1:0] WIN_HEIGHT_RST = 7'd25;

	localparam logic [COLOR_W-1:0] FG_DEFAULT = 5'd8;
	localparam logic [COLOR_W-1:0] BG_DEFAULT = 5'd0;
	localparam logic [COLOR_W-1:0] ATTR_BOOST = 5'd8;

	localparam logic [7:0] CH_NUL     = 8'd0;
	localparam logic [7:0] CH_NEWLINE = 8'd10;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	// line-drawing codes and their box glyphs
	localparam logic [22:0] ACS_VLINE    = 23'h400078;
	localparam logic [22:0] ACS_HLINE    = 23'h400071;
	localparam logic [22:0] ACS_LLCORNER = 23'h40006D;
	localparam logic [22:0] ACS_ULCORNER = 23'h40006C;
	localparam logic [22:0] ACS_URCORNER = 23'h40006B;
	localparam logic [22:0] ACS_LRCORNER = 23'h40006A;
	localparam logic [22:0] ACS_BTEE     = 23'h400076;
	localparam logic [22:0] ACS_LTEE     = 23'h400074;
	localparam logic [22:0] ACS_RTEE     = 23'h400075;
	localparam logic [22:0] ACS_TTEE     = 23'h400077;
	localparam logic [22:0] ACS_PLUS     = 23'h40006E;

	localparam logic [7:0] GLYPH_VLINE    = 8'd179;
	localparam logic [7:0] GLYPH_HLINE    = 8'd196;
	localparam logic [7:0] GLYPH_LLCORNER = 8'd192;
	localparam logic [7:0] GLYPH_ULCORNER = 8'd218;
	localparam logic [7:0] GLYPH_URCORNER = 8'd191;
	localparam logic [7:0] GLYPH_LRCORNER = 8'd217;
	localparam logic [7:0] GLYPH_BTEE     = 8'd193;
	localparam logic [7:0] GLYPH_LTEE     = 8'd195;
	localparam logic [7:0] GLYPH_RTEE     = 8'd180;
	localparam logic [7:0] GLYPH_TTEE     = 8'd194;
	localparam logic [7:0] GLYPH_PLUS     = 8'd197;

	typedef enum logic [0:0] {
		REG_WIN_WIDTH  = 1'b0,
		REG_WIN_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		CMD_PRINT    = 3'd0,
		CMD_ADD      = 3'd1,
		CMD_MOVE     = 3'd2,
		CMD_ERASE    = 3'd3,
		CMD_ATTR_ON  = 3'd4,
		CMD_ATTR_OFF = 3'd5,
		CMD_DEF_PAIR = 3'd6,
		CMD_READ     = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ERASE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic        blink;
		logic        bold;
		logic [3:0]  bg_color;
		logic [3:0]  fg_color;
		logic [5:0]  pair_index;
		logic [6:0]  col;
		logic [5:0]  row;
		logic [22:0] char_code;
		cmd_t        command;
	} in_item_t;

	typedef struct packed {
		logic               redraw_pending;
		logic [5:0]         cursor_row;
		logic [7:0]         cursor_col;
		logic               row_touched;
		logic [COLOR_W-1:0] cell_bg;
		logic [COLOR_W-1:0] cell_fg;
		logic [7:0]         cell_char;
		logic               status;
	} out_item_t;

	typedef struct packed {
		logic [7:0]         ch;
		logic [COLOR_W-1:0] fg;
		logic [COLOR_W-1:0] bg;
	} cell_t;

	function automatic logic [7:0] acs_glyph(input logic [22:0] code);
		logic [7:0] g;
		case (code)
			ACS_VLINE:    g = GLYPH_VLINE;
			ACS_HLINE:    g = GLYPH_HLINE;
			ACS_LLCORNER: g = GLYPH_LLCORNER;
			ACS_ULCORNER: g = GLYPH_ULCORNER;
			ACS_URCORNER: g = GLYPH_URCORNER;
			ACS_LRCORNER: g = GLYPH_LRCORNER;
			ACS_BTEE:     g = GLYPH_BTEE;
			ACS_LTEE:     g = GLYPH_LTEE;
			ACS_RTEE:     g = GLYPH_RTEE;
			ACS_TTEE:     g = GLYPH_TTEE;
			ACS_PLUS:     g = GLYPH_PLUS;
			default:      g = code[7:0];
		endcase
		return g;
	endfunction

endpackage

### rtl/twcs_ram.sv
// ----------------------------------------------------------------------------
// twcs_ram
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
module twcs_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/text_window_cell_store.sv
// ----------------------------------------------------------------------------
// text_window_cell_store
// Character-cell text window with cursor, colours and a colour-pair table.
// ----------------------------------------------------------------------------
// Print, add, move, attr off and define pair are done in the idle state and
// their result is registered for the next cycle, so they can follow back to
// back while the output is not stalled. Attr on and read cell pass through
// the finish state for the registered read of the pair table or the cell
// memory. Erase walks the visible cells through the single write port of the
// cell memory, one cell per cycle, then sends its result from the finish state.
// After reset a clearing pass writes every one of MAX_ROWS*MAX_COLS cells
// before the first item is taken; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module text_window_cell_store #(
	parameter int MAX_COLS   = 128,
	parameter int MAX_ROWS   = 64,
	parameter int PAIR_COUNT = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [twcs_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [twcs_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [twcs_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// command, char_code, row, col, pair_index, fg_color, bg_color, bold, blink
	input  logic [twcs_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// status, cell_char, cell_fg, cell_bg, row_touched, cursor_col, cursor_row,
	// redraw_pending
	output logic [twcs_pkg::OUT_TDATA_W-1:0]   m_tdata
);

	import twcs_pkg::*;

	localparam int CW    = $clog2(MAX_COLS + 1);
	localparam int CIW   = $clog2(MAX_COLS);
	localparam int HW    = $clog2(MAX_ROWS + 1);
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int AW    = $clog2(CELLS);
	localparam int PW    = $clog2(PAIR_COUNT);

	logic [WIN_WIDTH_W-1:0]  win_width_q;
	logic [WIN_HEIGHT_W-1:0] win_height_q;
	logic                    cfg_wr;
	reg_idx_t                cfg_idx;

	logic [CW-1:0] w_eff;
	logic [HW-1:0] h_eff;

	state_t state_q, state_d;

	logic [CW-1:0]       cur_col_q, cur_col_d;
	logic [RW-1:0]       cur_row_q, cur_row_d;
	logic [COLOR_W-1:0]  cur_fg_q, cur_fg_d;
	logic [COLOR_W-1:0]  cur_bg_q, cur_bg_d;
	logic                dirty_q, dirty_d;
	logic [MAX_ROWS-1:0] row_marks_q, marks_d;

	logic [RW-1:0]  sw_row_q, sw_last_row_q;
	logic [CIW-1:0] sw_col_q, sw_last_col_q;
	logic           sw_start, sw_step, sw_done;
	logic [AW-1:0]  sweep_addr;

	cmd_t pend_cmd_q;
	logic pend_status_q, pend_bold_q, pend_blink_q, pend_rt_q;
	logic pend_load;

	in_item_t  in_item;
	out_item_t out_q, out_d;
	logic      out_valid_q, out_load, out_free;
	logic      accept, status_d, put;
	logic [7:0] put_ch;

	logic          cell_we, cell_re;
	logic [AW-1:0] cell_waddr, cell_raddr, cur_addr, in_addr;
	cell_t         cell_wdata, cell_rdata;

	logic          pair_we, pair_re;
	logic [PW-1:0] pair_addr;
	logic [PAIR_W-1:0] pair_wdata, pair_rdata;

	logic row_in, col_in, nl_ok, move_ok, pair_ok;

	// configuration
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[REG_ADDR_LSB]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_width_q  <= WIN_WIDTH_RST;
			win_height_q <= WIN_HEIGHT_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_WIN_WIDTH:  win_width_q  <= pwdata[WIN_WIDTH_W-1:0];
				REG_WIN_HEIGHT: win_height_q <= pwdata[WIN_HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_WIN_WIDTH:  prdata = APB_DATA_W'(win_width_q);
			REG_WIN_HEIGHT: prdata = APB_DATA_W'(win_height_q);
			default:        prdata = '0;
		endcase
	end

	always_comb begin
		if (win_width_q == '0) begin
			w_eff = CW'(1);
		end else if (int'(win_width_q) > MAX_COLS) begin
			w_eff = CW'(MAX_COLS);
		end else begin
			w_eff = CW'(win_width_q);
		end
		if (win_height_q == '0) begin
			h_eff = HW'(1);
		end else if (int'(win_height_q) > MAX_ROWS) begin
			h_eff = HW'(MAX_ROWS);
		end else begin
			h_eff = HW'(win_height_q);
		end
	end

	// memories
	twcs_ram #(
		.DEPTH(CELLS),
		.WIDTH(CELL_W)
	) u_cell_ram (
		.clk    (clk),
		.wr_en  (cell_we),
		.wr_addr(cell_waddr),
		.wr_data(cell_wdata),
		.rd_en  (cell_re),
		.rd_addr(cell_raddr),
		.rd_data(cell_rdata)
	);

	twcs_ram #(
		.DEPTH(PAIR_COUNT),
		.WIDTH(PAIR_W)
	) u_pair_ram (
		.clk    (clk),
		.wr_en  (pair_we),
		.wr_addr(pair_addr),
		.wr_data(pair_wdata),
		.rd_en  (pair_re),
		.rd_addr(pair_addr),
		.rd_data(pair_rdata)
	);

	// item decode
	assign in_item  = in_item_t'(s_tdata[$bits(in_item_t)-1:0]);
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;

	assign cur_addr   = AW'(int'(cur_row_q) * MAX_COLS + int'(cur_col_q));
	assign in_addr    = AW'(int'(in_item.row) * MAX_COLS + int'(in_item.col));
	assign sweep_addr = AW'(int'(sw_row_q) * MAX_COLS + int'(sw_col_q));
	assign sw_done    = (sw_row_q == sw_last_row_q) && (sw_col_q == sw_last_col_q);

	assign row_in  = int'(cur_row_q) < int'(h_eff);
	assign col_in  = int'(cur_col_q) < int'(w_eff);
	assign nl_ok   = (int'(cur_row_q) + 1) < int'(h_eff);
	assign move_ok = (int'(in_item.col) < int'(w_eff)) && (int'(in_item.row) < int'(h_eff));
	assign pair_ok = int'(in_item.pair_index) < PAIR_COUNT;

	assign pair_addr  = PW'(in_item.pair_index);
	assign pair_wdata = {in_item.fg_color, in_item.bg_color};
	assign cell_raddr = in_addr;

	always_comb begin
		state_d   = state_q;
		cur_col_d = cur_col_q;
		cur_row_d = cur_row_q;
		cur_fg_d  = cur_fg_q;
		cur_bg_d  = cur_bg_q;
		dirty_d   = dirty_q;
		marks_d   = row_marks_q;
		status_d  = STATUS_OK;
		put       = 1'b0;
		put_ch    = in_item.char_code[7:0];
		cell_we   = 1'b0;
		cell_waddr = sweep_addr;
		cell_wdata = '0;
		cell_re   = 1'b0;
		pair_we   = 1'b0;
		pair_re   = 1'b0;
		sw_start  = 1'b0;
		sw_step   = 1'b0;
		pend_load = 1'b0;
		out_load  = 1'b0;
		out_d     = '0;

		case (state_q)
			ST_CLEAR: begin
				cell_we = 1'b1;
				sw_step = 1'b1;
				if (sw_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_ERASE: begin
				cell_we = 1'b1;
				sw_step = 1'b1;
				if (sw_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					pend_load = 1'b1;
					case (in_item.command)
						CMD_PRINT: begin
							out_load = 1'b1;
							if (put_ch == CH_NEWLINE) begin
								if (nl_ok) begin
									cur_row_d = cur_row_q + RW'(1);
									cur_col_d = '0;
									dirty_d   = 1'b1;
								end else begin
									status_d = STATUS_FAIL;
								end
							end else if (put_ch != CH_NUL) begin
								if (!row_in) begin
									status_d = STATUS_FAIL;
								end else begin
									put     = col_in;
									dirty_d = 1'b1;
								end
							end else begin
								dirty_d = 1'b1;
							end
						end
						CMD_ADD: begin
							out_load = 1'b1;
							if (!row_in || !col_in) begin
								status_d = STATUS_FAIL;
							end else begin
								put    = 1'b1;
								put_ch = acs_glyph(in_item.char_code);
							end
						end
						CMD_MOVE: begin
							out_load = 1'b1;
							if (move_ok) begin
								cur_col_d = CW'(in_item.col);
								cur_row_d = RW'(in_item.row);
							end else begin
								status_d = STATUS_FAIL;
							end
						end
						CMD_ERASE: begin
							// row marks are never cleared, so the visible rows stay marked
							sw_start  = 1'b1;
							cur_col_d = '0;
							cur_row_d = '0;
							dirty_d   = 1'b1;
							state_d   = ST_ERASE;
						end
						CMD_ATTR_ON: begin
							pair_re  = pair_ok;
							status_d = pair_ok ? STATUS_OK : STATUS_FAIL;
							state_d  = ST_FINISH;
						end
						CMD_ATTR_OFF: begin
							out_load = 1'b1;
							cur_fg_d = FG_DEFAULT;
							cur_bg_d = BG_DEFAULT;
						end
						CMD_DEF_PAIR: begin
							out_load = 1'b1;
							pair_we  = pair_ok;
							status_d = pair_ok ? STATUS_OK : STATUS_FAIL;
						end
						CMD_READ: begin
							cell_re  = move_ok;
							status_d = move_ok ? STATUS_OK : STATUS_FAIL;
							state_d  = ST_FINISH;
						end
						default: ;
					endcase
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
					if (pend_cmd_q == CMD_ATTR_ON && pend_status_q == STATUS_OK) begin
						cur_fg_d = {1'b0, pair_rdata[7:4]} + (pend_bold_q ? ATTR_BOOST : '0);
						cur_bg_d = {1'b0, pair_rdata[3:0]} + (pend_blink_q ? ATTR_BOOST : '0);
					end
					if (pend_cmd_q == CMD_READ && pend_status_q == STATUS_OK) begin
						out_d.cell_char   = cell_rdata.ch;
						out_d.cell_fg     = cell_rdata.fg;
						out_d.cell_bg     = cell_rdata.bg;
						out_d.row_touched = pend_rt_q;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (put) begin
			cell_we    = 1'b1;
			cell_waddr = cur_addr;
			cell_wdata.ch = put_ch;
			cell_wdata.fg = cur_fg_q;
			cell_wdata.bg = cur_bg_q;
			marks_d[cur_row_q] = 1'b1;
			dirty_d    = 1'b1;
			cur_col_d  = cur_col_q + CW'(1);
		end

		out_d.status         = (state_q == ST_FINISH) ? pend_status_q : status_d;
		out_d.cursor_col     = 8'(cur_col_d);
		out_d.cursor_row     = 6'(cur_row_d);
		out_d.redraw_pending = dirty_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			cur_fg_q    <= FG_DEFAULT;
			cur_bg_q    <= BG_DEFAULT;
			dirty_q     <= 1'b0;
			row_marks_q <= '1;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cur_col_q   <= cur_col_d;
			cur_row_q   <= cur_row_d;
			cur_fg_q    <= cur_fg_d;
			cur_bg_q    <= cur_bg_d;
			dirty_q     <= dirty_d;
			row_marks_q <= marks_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_row_q      <= '0;
			sw_col_q      <= '0;
			sw_last_row_q <= RW'(MAX_ROWS - 1);
			sw_last_col_q <= CIW'(MAX_COLS - 1);
		end else if (sw_start) begin
			sw_row_q      <= '0;
			sw_col_q      <= '0;
			sw_last_row_q <= RW'(int'(h_eff) - 1);
			sw_last_col_q <= CIW'(int'(w_eff) - 1);
		end else if (sw_step) begin
			if (sw_col_q == sw_last_col_q) begin
				sw_col_q <= '0;
				sw_row_q <= sw_row_q + RW'(1);
			end else begin
				sw_col_q <= sw_col_q + CIW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_load) begin
			pend_cmd_q    <= in_item.command;
			pend_status_q <= status_d;
			pend_bold_q   <= in_item.bold;
			pend_blink_q  <= in_item.blink;
			pend_rt_q     <= row_marks_q[RW'(in_item.row)];
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - $bits(out_item_t)){1'b0}}, out_q};

endmodule

### rtl/twcs_checker.sv
// ----------------------------------------------------------------------------
// twcs_checker
// Port-level checks for the text window cell store, bound to the top level.
// ----------------------------------------------------------------------------
module twcs_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [twcs_pkg::IN_TDATA_W-1:0]  s_tdata,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [twcs_pkg::OUT_TDATA_W-1:0] m_tdata
);

	import twcs_pkg::*;

	in_item_t  in_item;
	out_item_t out_item;
	logic      seen_dirty_q;

	assign in_item  = in_item_t'(s_tdata[$bits(in_item_t)-1:0]);
	assign out_item = out_item_t'(m_tdata[$bits(out_item_t)-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_dirty_q <= 1'b0;
		end else if (m_tvalid && m_tready && out_item.redraw_pending) begin
			seen_dirty_q <= 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while stalled");

	a_move_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && in_item.command == CMD_MOVE) |=>
		(m_tvalid && (out_item.status == STATUS_FAIL ||
		(out_item.cursor_col == 8'($past(in_item.col)) &&
		out_item.cursor_row == $past(in_item.row)))))
		else $error("move result missing or cursor wrong");

	a_fail_cells_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_item.status == STATUS_FAIL) |->
		(out_item.cell_char == '0 && out_item.cell_fg == '0 &&
		out_item.cell_bg == '0 && out_item.row_touched == 1'b0))
		else $error("cell fields set on a rejected command");

	a_dirty_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && seen_dirty_q) |-> out_item.redraw_pending)
		else $error("redraw pending dropped");

endmodule

bind text_window_cell_store twcs_checker u_twcs_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
